FILE: hdl/rar_pkg.sv
// rar_pkg: shared widths, mode codes and core command types for the rational unit
// no dependencies; imported by rar_mul, rar_core, rational_arith_reduce_unit and the bench

package rar_pkg;

    // field widths of the beat
    localparam int MODE_W    = 4;
    localparam int NUM_W     = 16;
    localparam int DEN_W     = 15;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    // datapath widths
    localparam int MUL_W  = NUM_W + 1;
    localparam int CORE_W = 32;
    localparam int CNT_W  = $clog2(CORE_W);
    localparam int ADD_W  = CORE_W + 1;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 4'd3;
    localparam logic [MODE_W-1:0] MODE_GT  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_LT  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_GE  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LE  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_EQ  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_NE  = 4'd9;

    // commands to the iterative gcd / divide core
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_GCD_LOAD   = 3'd1,
        OP_GCD_STEP   = 3'd2,
        OP_SCALE_STEP = 3'd3,
        OP_DIV_LOAD   = 3'd4,
        OP_DIV_STEP   = 3'd5
    } t_core_op;

    typedef struct packed {
        t_core_op           op;
        logic [CORE_W-1:0]  opa;
        logic [CORE_W-1:0]  opb;
    } t_core_cmd;

    typedef struct packed {
        logic gcd_done;
        logic scale_done;
        logic div_last;
    } t_core_stat;

endpackage

FILE: hdl/rar_mul.sv
// rar_mul: registered signed multiplier shared by all product steps
// depends on rar_pkg for MUL_W

module rar_mul
    import rar_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [2*MUL_W-1:0] o_p
);

    logic signed [2*MUL_W-1:0] r_p;

    // one product per cycle, result registered for the cycle after its operands
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: hdl/rar_core.sv
// rar_core: iterative binary gcd, power-of-two rescale and restoring divide
// depends on rar_pkg for core command and status types; one shared subtractor

module rar_core
    import rar_pkg::*;
(
    input  logic              i_clk,
    input  t_core_cmd         i_cmd,
    output t_core_stat        o_stat,
    output logic [CORE_W-1:0] o_quot
);

    logic [CORE_W-1:0] r_u, n_u;
    logic [CORE_W-1:0] r_v, n_v;
    logic [CORE_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CORE_W-1:0] w_x;
    logic [CORE_W:0]   w_diff;
    logic              w_ge;

    // shared subtractor: gcd difference or trial remainder
    always_comb begin
        if (i_cmd.op == OP_DIV_STEP) begin
            w_x = {r_rem[CORE_W-2:0], r_u[CORE_W-1]};
        end else begin
            w_x = r_u;
        end
        w_diff = {1'b0, w_x} - {1'b0, r_v};
        w_ge   = ~w_diff[CORE_W];
    end

    // next values per command
    always_comb begin
        n_u   = r_u;
        n_v   = r_v;
        n_rem = r_rem;
        n_k   = r_k;
        n_cnt = r_cnt;
        case (i_cmd.op)
            OP_GCD_LOAD: begin
                n_u = i_cmd.opa;
                n_v = i_cmd.opb;
                n_k = '0;
            end
            OP_GCD_STEP: begin
                if (!r_u[0] && !r_v[0]) begin
                    // common factor of two
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CNT_W'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (w_ge) begin
                    n_u = w_diff[CORE_W-1:0] >> 1;
                end else begin
                    // keep u the larger one
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            OP_SCALE_STEP: begin
                n_v = r_v << 1;
                n_k = r_k - CNT_W'(1);
            end
            OP_DIV_LOAD: begin
                n_u   = i_cmd.opa;
                n_rem = '0;
                n_cnt = '0;
            end
            OP_DIV_STEP: begin
                n_rem = w_ge ? w_diff[CORE_W-1:0] : w_x;
                n_u   = {r_u[CORE_W-2:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_rem <= n_rem;
        r_k   <= n_k;
        r_cnt <= n_cnt;
    end

    assign o_stat.gcd_done   = (r_u == '0);
    assign o_stat.scale_done = (r_k == '0);
    assign o_stat.div_last   = (r_cnt == CNT_W'(CORE_W - 1));
    assign o_quot            = r_u;

endmodule

FILE: hdl/rational_arith_reduce_unit.sv
// rational_arith_reduce_unit: fraction add/sub/mul/div with gcd reduction, and compares
// compares, unused modes and division by zero go from the products and compare to the strobe
// a zero numerator stops at the abs step; others run gcd, power-of-two rescale, both divides
// throughput: one beat at a time, busy stays high until the result strobe
// all arithmetic goes through one multiplier, one add/sub and the gcd/divide subtractor
// reset: synchronous active low, returns to idle with no strobe pending

module rational_arith_reduce_unit
    import rar_pkg::*;
#(
    parameter int OPERAND_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [MODE_W-1:0]           i_mode,
    input  logic signed [NUM_W-1:0]     i_a_num,
    input  logic [DEN_W-1:0]            i_a_den,
    input  logic signed [NUM_W-1:0]     i_b_num,
    input  logic [DEN_W-1:0]            i_b_den,
    output logic                        o_done,
    output logic signed [RES_NUM_W-1:0] o_result_num,
    output logic [RES_DEN_W-1:0]        o_result_den,
    output logic                        o_compare_true,
    output logic                        o_status
);

    localparam int NUM_KEEP = (OPERAND_BITS < NUM_W) ? OPERAND_BITS : NUM_W;
    localparam int DEN_KEEP = (OPERAND_BITS - 1 < DEN_W) ? OPERAND_BITS - 1 : DEN_W;
    localparam int NUM_SH   = NUM_W - NUM_KEEP;
    localparam logic [DEN_W-1:0] DEN_MASK = DEN_W'((1 << DEN_KEEP) - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_PREP  = 10'b00_0000_0100,
        S_ABS   = 10'b00_0000_1000,
        S_GCD   = 10'b00_0001_0000,
        S_SCALE = 10'b00_0010_0000,
        S_DIVN  = 10'b00_0100_0000,
        S_QN    = 10'b00_1000_0000,
        S_DIVD  = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_step;

    // operand registers
    logic [MODE_W-1:0]        r_mode;
    logic signed [MUL_W-1:0]  r_an, r_bn;
    logic [DEN_W-1:0]         r_ad, r_bd;
    logic signed [CORE_W-1:0] r_lhs, r_rhs, r_den;
    logic signed [ADD_W-1:0]  r_num;
    logic [CORE_W-1:0]        r_mag, r_qn;
    logic r_neg, r_zero, r_cmp, r_stat;

    // output registers
    logic                        r_done;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]        r_res_den;
    logic                        r_res_cmp, r_res_stat;

    // input conditioning
    logic signed [NUM_W-1:0] w_a_sh, w_b_sh, w_a_ext, w_b_ext;
    logic [DEN_W-1:0]        w_ad_m, w_bd_m, w_ad, w_bd;
    logic signed [MUL_W-1:0] w_an17, w_bn17;
    logic                    w_flip;

    assign w_a_sh  = i_a_num <<< NUM_SH;
    assign w_b_sh  = i_b_num <<< NUM_SH;
    assign w_a_ext = w_a_sh >>> NUM_SH;
    assign w_b_ext = w_b_sh >>> NUM_SH;
    assign w_ad_m  = i_a_den & DEN_MASK;
    assign w_bd_m  = i_b_den & DEN_MASK;
    assign w_ad    = (w_ad_m == '0) ? DEN_W'(1) : w_ad_m;
    assign w_bd    = (w_bd_m == '0) ? DEN_W'(1) : w_bd_m;
    assign w_an17  = {w_a_ext[NUM_W-1], w_a_ext};
    assign w_bn17  = {w_b_ext[NUM_W-1], w_b_ext};
    // division moves the divisor's sign onto the numerator
    assign w_flip  = (i_mode == MODE_DIV) && w_b_ext[NUM_W-1];

    // multiplier operand select per product step
    logic signed [MUL_W-1:0]   w_ad_s, w_bd_s, w_ma, w_mb;
    logic signed [2*MUL_W-1:0] w_prod;

    assign w_ad_s = $signed({{(MUL_W-DEN_W){1'b0}}, r_ad});
    assign w_bd_s = $signed({{(MUL_W-DEN_W){1'b0}}, r_bd});

    always_comb begin
        case (r_step)
            2'd1: begin
                w_ma = r_bn;
                w_mb = w_ad_s;
            end
            2'd2: begin
                w_ma = w_ad_s;
                w_mb = (r_mode == MODE_DIV) ? r_bn : w_bd_s;
            end
            default: begin
                w_ma = r_an;
                w_mb = (r_mode == MODE_MUL) ? r_bn : w_bd_s;
            end
        endcase
    end

    rar_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // shared add/sub: combine, compare, absolute value, final sign
    logic signed [ADD_W-1:0] w_x, w_y, w_sum;
    logic                    w_inv;

    always_comb begin
        case (r_state)
            S_PREP: begin
                w_x   = {r_lhs[CORE_W-1], r_lhs};
                w_y   = {r_rhs[CORE_W-1], r_rhs};
                w_inv = (r_mode != MODE_ADD);
            end
            S_ABS: begin
                w_x   = '0;
                w_y   = r_num;
                w_inv = 1'b1;
            end
            default: begin
                w_x   = '0;
                w_y   = {1'b0, r_qn};
                w_inv = 1'b1;
            end
        endcase
        w_sum = w_x + (w_inv ? ~w_y : w_y) + {{(ADD_W-1){1'b0}}, w_inv};
    end

    // compare outcome from lhs - rhs
    logic w_dneg, w_dzero, w_cmp, w_to_abs;

    assign w_dneg  = w_sum[ADD_W-1];
    assign w_dzero = (w_sum == '0);

    always_comb begin
        case (r_mode)
            MODE_GT: w_cmp = !w_dneg && !w_dzero;
            MODE_LT: w_cmp = w_dneg;
            MODE_GE: w_cmp = !w_dneg;
            MODE_LE: w_cmp = w_dneg || w_dzero;
            MODE_EQ: w_cmp = w_dzero;
            MODE_NE: w_cmp = !w_dzero;
            default: w_cmp = 1'b0;
        endcase
    end

    assign w_to_abs = (r_mode == MODE_ADD) || (r_mode == MODE_SUB) ||
                      (r_mode == MODE_MUL) || ((r_mode == MODE_DIV) && (r_bn != '0));

    // gcd / divide core
    t_core_cmd         w_cmd;
    t_core_stat        w_stat;
    logic [CORE_W-1:0] w_quot;
    logic [CORE_W-1:0] w_mag;

    assign w_mag = r_num[ADD_W-1] ? w_sum[CORE_W-1:0] : r_num[CORE_W-1:0];

    always_comb begin
        w_cmd.op  = OP_NOP;
        w_cmd.opa = r_mag;
        w_cmd.opb = r_den;
        case (r_state)
            S_ABS: begin
                w_cmd.op  = OP_GCD_LOAD;
                w_cmd.opa = w_mag;
            end
            S_GCD: begin
                if (!w_stat.gcd_done) begin
                    w_cmd.op = OP_GCD_STEP;
                end
            end
            S_SCALE: begin
                w_cmd.op = w_stat.scale_done ? OP_DIV_LOAD : OP_SCALE_STEP;
            end
            S_DIVN, S_DIVD: begin
                w_cmd.op = OP_DIV_STEP;
            end
            S_QN: begin
                w_cmd.op  = OP_DIV_LOAD;
                w_cmd.opa = r_den;
            end
            default: begin
            end
        endcase
    end

    rar_core u_core (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_quot (w_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_MUL;
            S_MUL:   if (r_step == 2'd3) n_state = S_PREP;
            S_PREP:  n_state = w_to_abs ? S_ABS : S_FIN;
            S_ABS:   n_state = (r_num == '0) ? S_FIN : S_GCD;
            S_GCD:   if (w_stat.gcd_done) n_state = S_SCALE;
            S_SCALE: if (w_stat.scale_done) n_state = S_DIVN;
            S_DIVN:  if (w_stat.div_last) n_state = S_QN;
            S_QN:    n_state = S_DIVD;
            S_DIVD:  if (w_stat.div_last) n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
            if (r_state == S_MUL) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= 2'd0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_mode <= i_mode;
                    r_an   <= w_flip ? -w_an17 : w_an17;
                    r_bn   <= w_flip ? -w_bn17 : w_bn17;
                    r_ad   <= w_ad;
                    r_bd   <= w_bd;
                    r_zero <= 1'b0;
                    r_cmp  <= 1'b0;
                    r_stat <= 1'b0;
                end
            end
            S_MUL: begin
                case (r_step)
                    2'd1:    r_lhs <= w_prod[CORE_W-1:0];
                    2'd2:    r_rhs <= w_prod[CORE_W-1:0];
                    2'd3:    r_den <= w_prod[CORE_W-1:0];
                    default: begin
                    end
                endcase
            end
            S_PREP: begin
                r_cmp <= w_cmp;
                if ((r_mode == MODE_ADD) || (r_mode == MODE_SUB)) begin
                    r_num <= w_sum;
                end else begin
                    r_num <= {r_lhs[CORE_W-1], r_lhs};
                end
                if (!w_to_abs) begin
                    r_zero <= 1'b1;
                end
                if ((r_mode == MODE_DIV) && (r_bn == '0)) begin
                    r_stat <= 1'b1;
                end
            end
            S_ABS: begin
                r_neg <= r_num[ADD_W-1];
                r_mag <= w_mag;
                if (r_num == '0) begin
                    r_zero <= 1'b1;
                end
            end
            S_QN: begin
                r_qn <= w_quot;
            end
            S_FIN: begin
                r_res_cmp  <= r_cmp;
                r_res_stat <= r_stat;
                if (r_zero) begin
                    r_res_num <= '0;
                    r_res_den <= RES_DEN_W'(1);
                end else begin
                    r_res_num <= r_neg ? w_sum[RES_NUM_W-1:0] : r_qn;
                    r_res_den <= w_quot[RES_DEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_num   = r_res_num;
    assign o_result_den   = r_res_den;
    assign o_compare_true = r_res_cmp;
    assign o_status       = r_res_stat;

endmodule

FILE: hdl/rar_chk.sv
// rar_chk: port-level checks on the rational unit's sequencing and result forms
// depends on rational_arith_reduce_unit ports; bound to it at the bottom of this file

module rar_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_result_num,
    input logic [30:0] o_result_den,
    input logic        o_compare_true,
    input logic        o_status
);

    // a result beat always closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without preceding busy cycle");

    // an accepted beat starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // reduced denominator is never zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result_den != '0))
        else $error("zero denominator on result beat");

    // flagged results (compare true or divide by zero) carry 0/1
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_compare_true || o_status)) |->
            ((o_result_num == '0) && (o_result_den == 31'd1)))
        else $error("flagged result is not 0/1");

    // error and compare flags never both set
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_compare_true && o_status))
        else $error("compare and status both set");

endmodule

bind rational_arith_reduce_unit rar_chk u_rar_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_result_num   (o_result_num),
    .o_result_den   (o_result_den),
    .o_compare_true (o_compare_true),
    .o_status       (o_status)
);

FILE: tb/tb_rational_arith_reduce_unit.sv
// tb_rational_arith_reduce_unit: self-checking bench for the fraction arithmetic unit
// depends on rar_pkg and rational_arith_reduce_unit; predicts each result beat in place
`timescale 1ns / 1ps

module tb_rational_arith_reduce_unit;
    import rar_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam logic signed [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic signed [NUM_W-1:0] NUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [DEN_W-1:0]        DEN_MAX = '1;

    typedef struct {
        logic signed [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0]        den;
        logic                        cmp;
        logic                        status;
    } t_frac_result;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [MODE_W-1:0]           i_mode = '0;
    logic signed [NUM_W-1:0]     i_a_num = '0;
    logic [DEN_W-1:0]            i_a_den = '0;
    logic signed [NUM_W-1:0]     i_b_num = '0;
    logic [DEN_W-1:0]            i_b_den = '0;
    logic                        o_done;
    logic signed [RES_NUM_W-1:0] o_result_num;
    logic [RES_DEN_W-1:0]        o_result_den;
    logic                        o_compare_true;
    logic                        o_status;

    t_frac_result expected_fracs[$];
    int           n_errors = 0;
    int           sender_idle_pct = 0;
    int           stall_cycles = 0;

    rational_arith_reduce_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .o_done         (o_done),
        .o_result_num   (o_result_num),
        .o_result_den   (o_result_den),
        .o_compare_true (o_compare_true),
        .o_status       (o_status)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sign to numerator, strip the gcd of the magnitudes
    function automatic t_frac_result reduce_fraction(input longint num, input longint den);
        t_frac_result r;
        longint       mag_n, mag_d, x, y, t;
        logic         neg;
        r.num    = '0;
        r.den    = 1;
        r.cmp    = 1'b0;
        r.status = 1'b0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num == 0 || den == 0) return r;
        neg   = num < 0;
        mag_n = neg ? -num : num;
        mag_d = den;
        x = mag_n;
        y = mag_d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mag_n = mag_n / x;
        mag_d = mag_d / x;
        r.num = RES_NUM_W'(neg ? -mag_n : mag_n);
        r.den = RES_DEN_W'(mag_d);
        return r;
    endfunction

    // expected result beat for one command
    function automatic t_frac_result predict_rational(
        input logic [MODE_W-1:0]       mode,
        input logic signed [NUM_W-1:0] a_num,
        input logic [DEN_W-1:0]        a_den,
        input logic signed [NUM_W-1:0] b_num,
        input logic [DEN_W-1:0]        b_den
    );
        t_frac_result r;
        longint       an, ad, bn, bd, lhs, rhs;
        an = a_num;
        bn = b_num;
        ad = (a_den == 0) ? 1 : longint'(a_den);
        bd = (b_den == 0) ? 1 : longint'(b_den);
        lhs = an * bd;
        rhs = bn * ad;
        r.num    = '0;
        r.den    = 1;
        r.cmp    = 1'b0;
        r.status = 1'b0;
        case (mode)
            MODE_ADD: r = reduce_fraction(lhs + rhs, ad * bd);
            MODE_SUB: r = reduce_fraction(lhs - rhs, ad * bd);
            MODE_MUL: r = reduce_fraction(an * bn, ad * bd);
            MODE_DIV: begin
                if (bn == 0) r.status = 1'b1;
                else r = reduce_fraction(lhs, ad * bn);
            end
            MODE_GT: r.cmp = lhs > rhs;
            MODE_LT: r.cmp = lhs < rhs;
            MODE_GE: r.cmp = lhs >= rhs;
            MODE_LE: r.cmp = lhs <= rhs;
            MODE_EQ: r.cmp = lhs == rhs;
            MODE_NE: r.cmp = lhs != rhs;
            default: ;
        endcase
        return r;
    endfunction

    // one command beat; start stays high on return so the next beat can follow at once
    task automatic send_beat(
        input logic [MODE_W-1:0]       mode,
        input logic signed [NUM_W-1:0] a_num,
        input logic [DEN_W-1:0]        a_den,
        input logic signed [NUM_W-1:0] b_num,
        input logic [DEN_W-1:0]        b_den
    );
        // idle cycles with noise on the fields
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start   <= 1'b0;
            i_mode  <= MODE_W'($urandom);
            i_a_num <= NUM_W'($urandom);
            i_a_den <= DEN_W'($urandom);
            i_b_num <= NUM_W'($urandom);
            i_b_den <= DEN_W'($urandom);
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_a_num <= a_num;
        i_a_den <= a_den;
        i_b_num <= b_num;
        i_b_den <= b_den;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_fracs.push_back(predict_rational(mode, a_num, a_den, b_num, b_den));
    endtask

    // result beat check against the oldest prediction
    always @(posedge i_clk) begin
        t_frac_result want;
        if (i_rst_n && o_done) begin
            if (expected_fracs.size() == 0) begin
                $display("%0t: unexpected result beat num %0d den %0d cmp %0b status %0b",
                         $time, o_result_num, o_result_den, o_compare_true, o_status);
                n_errors++;
            end else begin
                want = expected_fracs.pop_front();
                if (o_result_num !== want.num) begin
                    $display("%0t: result_num expected %0d actual %0d",
                             $time, want.num, o_result_num);
                    n_errors++;
                end
                if (o_result_den !== want.den) begin
                    $display("%0t: result_den expected %0d actual %0d",
                             $time, want.den, o_result_den);
                    n_errors++;
                end
                if (o_compare_true !== want.cmp) begin
                    $display("%0t: compare_true expected %0b actual %0b",
                             $time, want.cmp, o_compare_true);
                    n_errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** rational_arith_reduce_unit: FAILED **");
                $finish;
            end
        end
    end

    // extreme operands through the four operations
    task automatic test_arith_extremes();
        send_beat(MODE_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
        send_beat(MODE_SUB, NUM_MAX, 1, NUM_MIN, 1);
        send_beat(MODE_MUL, NUM_MIN, 1, NUM_MIN, 1);
        send_beat(MODE_DIV, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX - 1'b1);
        send_beat(MODE_ADD, 1, DEN_MAX, 1, DEN_MAX - 1'b1);
        send_beat(MODE_MUL, 12, 18, -15, 20);
    endtask

    // zero denominators, zero result, division by a zero fraction
    task automatic test_special_cases();
        send_beat(MODE_ADD, 3, 0, 5, 0);
        send_beat(MODE_SUB, 7, 14, 1, 2);
        send_beat(MODE_MUL, 0, 5, 9, 4);
        send_beat(MODE_DIV, 5, 3, 0, 7);
        send_beat(MODE_DIV, 3, 4, -6, 0);
    endtask

    // each compare mode, equal and unequal pairs
    task automatic test_compare_modes();
        send_beat(MODE_GT, 1, 2, 1, 3);
        send_beat(MODE_LT, -1, 2, 1, 3);
        send_beat(MODE_GE, 2, 4, 1, 2);
        send_beat(MODE_LE, -3, 9, -1, 3);
        send_beat(MODE_EQ, 4, 0, 4, 1);
        send_beat(MODE_NE, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
    endtask

    // mode codes above the last compare give 0/1
    task automatic test_unused_modes();
        for (int m = int'(MODE_NE) + 1; m < (1 << MODE_W); m++)
            send_beat(MODE_W'(m), NUM_MAX, 3, -7, DEN_MAX);
    endtask

    // numerator mix: extremes, small values, full range
    function automatic logic signed [NUM_W-1:0] pick_num();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return NUM_MIN;
                1: return NUM_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        if (sel < 5) return NUM_W'($urandom_range(0, 128) - 64);
        return NUM_W'($urandom);
    endfunction

    // denominator mix: zero, maximum, small values, full range
    function automatic logic [DEN_W-1:0] pick_den();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 0;
        if (sel == 1) return DEN_MAX;
        if (sel < 6) return DEN_W'($urandom_range(1, 64));
        return DEN_W'($urandom);
    endfunction

    // random commands at the given sender idle rate
    task automatic test_random(input int n_items, input int idle_pct);
        logic [MODE_W-1:0]       mode;
        logic signed [NUM_W-1:0] an, bn;
        logic [DEN_W-1:0]        ad, bd;
        int                      k, base_n, base_d;
        sender_idle_pct = idle_pct;
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 6) mode = MODE_W'($urandom_range(int'(MODE_NE) + 1,
                                                                 (1 << MODE_W) - 1));
            else mode = MODE_W'($urandom_range(int'(MODE_ADD), int'(MODE_NE)));
            an = pick_num();
            ad = pick_den();
            bn = pick_num();
            bd = pick_den();
            // equal fractions in scaled form, only for the compares
            if (mode >= MODE_GT && mode <= MODE_NE && $urandom_range(0, 3) == 0) begin
                base_n = $urandom_range(0, 2000) - 1000;
                base_d = $urandom_range(1, 1000);
                k      = $urandom_range(1, 32);
                an = NUM_W'(base_n);
                ad = DEN_W'(base_d);
                bn = NUM_W'(base_n * k);
                bd = DEN_W'(base_d * k);
                if ($urandom_range(0, 1)) begin
                    an = bn;
                    ad = bd;
                    bn = NUM_W'(base_n);
                    bd = DEN_W'(base_d);
                end
            end
            if (mode == MODE_DIV && $urandom_range(0, 9) == 0) bn = 0;
            send_beat(mode, an, ad, bn, bd);
        end
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 0;
        test_arith_extremes();
        test_special_cases();
        test_compare_modes();
        test_unused_modes();

        test_random(540, 36);
        test_random(540, 55);
        test_random(520, 0);

        // drain outstanding beats, then watch for stray strobes
        start <= 1'b0;
        while (expected_fracs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("** rational_arith_reduce_unit: PASSED **");
        end else begin
            $display("** rational_arith_reduce_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rar_pkg.sv
hdl/rar_mul.sv
hdl/rar_core.sv
hdl/rational_arith_reduce_unit.sv
hdl/rar_chk.sv
tb/tb_rational_arith_reduce_unit.sv
